// ----- rtl/prr_pkg.sv -----
// ============================================================================
// prr_pkg
// Shared types and defaults for the priority round-robin run queue.
// ============================================================================
package prr_pkg;

    localparam int DEFAULT_NUM_CPUS     = 64;
    localparam int DEFAULT_MAX_PRIORITY = 7;
    localparam int SLICE_W              = 32;

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_DEQUEUE = 3'd1,
        OP_DETACH  = 3'd2,
        OP_PREEMPT = 3'd3,
        OP_LENGTH  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FAIL = 2'd1,
        STATUS_NONE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } state_t;

endpackage

// ----- rtl/prr_ram.sv -----
// ============================================================================
// prr_ram
// Single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module prr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/priority_round_robin_run_queue.sv -----
// ============================================================================
// priority_round_robin_run_queue
// Run queue of virtual CPUs with one FIFO per priority level, kept as doubly
// linked lists in per-CPU link memories.
// ============================================================================
// The accept cycle of a transaction reads the link and entry memories
// (registered read), and the next cycle writes them back and loads the
// result register. A new transaction is taken in the cycle after that
// while the result side keeps up, so a transaction is not accepted before
// the previous one has been written back. After reset the block clears the
// queued flags in the entry memory and accepts nothing during that pass.
// Levels run from 0 (lowest) to MAX_PRIORITY (highest); dequeue serves the
// highest non-empty level in FIFO order.
module priority_round_robin_run_queue
    import prr_pkg::*;
#(
    parameter int NUM_CPUS     = DEFAULT_NUM_CPUS,
    parameter int MAX_PRIORITY = DEFAULT_MAX_PRIORITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          operation,
    input  logic [$clog2(NUM_CPUS)-1:0]         cpu_id,
    input  logic [$clog2(MAX_PRIORITY+1)-1:0]   priority_req,
    input  logic [SLICE_W-1:0]                  slice_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [$clog2(NUM_CPUS)-1:0]         chosen_cpu,
    output logic [SLICE_W-1:0]                  chosen_slice,
    output logic                                preempt_needed,
    output logic [$clog2(NUM_CPUS+1)-1:0]       queue_length
);

    localparam int CPU_W  = $clog2(NUM_CPUS);
    localparam int PRIO_W = $clog2(MAX_PRIORITY + 1);
    localparam int LEVELS = MAX_PRIORITY + 1;
    localparam int CNT_W  = $clog2(NUM_CPUS + 1);
    localparam int META_W = 1 + PRIO_W + SLICE_W;

    state_t              state_reg, state_next;
    logic [CPU_W-1:0]    clr_addr_reg, clr_addr_next;

    logic [CPU_W-1:0]    head_reg  [LEVELS];
    logic [CPU_W-1:0]    head_next [LEVELS];
    logic [CPU_W-1:0]    tail_reg  [LEVELS];
    logic [CPU_W-1:0]    tail_next [LEVELS];
    logic [CNT_W-1:0]    count_reg  [LEVELS];
    logic [CNT_W-1:0]    count_next [LEVELS];

    op_t                 op_reg, op_next;
    logic [CPU_W-1:0]    cpu_reg, cpu_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [SLICE_W-1:0]  slice_reg, slice_next;
    logic                in_range_reg, in_range_next;
    logic                found_reg, found_next;

    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [CPU_W-1:0]    chosen_cpu_reg, chosen_cpu_next;
    logic [SLICE_W-1:0]  chosen_slice_reg, chosen_slice_next;
    logic                preempt_reg, preempt_next;
    logic [CNT_W-1:0]    qlen_reg, qlen_next;

    logic                rd_en;
    logic [CPU_W-1:0]    rd_addr;
    logic                next_we, prev_we, meta_we;
    logic [CPU_W-1:0]    next_waddr, prev_waddr, meta_waddr;
    logic [CPU_W-1:0]    next_wdata, prev_wdata;
    logic [META_W-1:0]   meta_wdata;
    logic [CPU_W-1:0]    next_rd, prev_rd;
    logic [META_W-1:0]   meta_rd;

    logic                any_found;
    logic [PRIO_W-1:0]   top_level;
    logic                rd_queued;
    logic [PRIO_W-1:0]   rd_prio;
    logic [SLICE_W-1:0]  rd_slice;
    logic                do_unlink;
    logic                is_head, is_tail;
    logic                pre_any;

    prr_ram #(
        .WIDTH (CPU_W),
        .DEPTH (NUM_CPUS)
    ) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    prr_ram #(
        .WIDTH (CPU_W),
        .DEPTH (NUM_CPUS)
    ) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_waddr),
        .wr_data (prev_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    prr_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_CPUS)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (meta_rd)
    );

    assign rd_queued = meta_rd[META_W-1];
    assign rd_prio   = meta_rd[SLICE_W +: PRIO_W];
    assign rd_slice  = meta_rd[SLICE_W-1:0];

    always_comb
    begin
        any_found = 1'b0;
        top_level = '0;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            if (count_reg[lv] != '0)
            begin
                any_found = 1'b1;
                top_level = PRIO_W'(lv);
            end
        end
    end

    always_comb
    begin
        pre_any = 1'b0;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            if (PRIO_W'(lv) > prio_reg && count_reg[lv] != '0)
            begin
                pre_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        op_next           = op_reg;
        cpu_next          = cpu_reg;
        prio_next         = prio_reg;
        slice_next        = slice_reg;
        in_range_next     = in_range_reg;
        found_next        = found_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        chosen_cpu_next   = chosen_cpu_reg;
        chosen_slice_next = chosen_slice_reg;
        preempt_next      = preempt_reg;
        qlen_next         = qlen_reg;
        in_stall          = 1'b1;
        rd_en             = 1'b0;
        rd_addr           = cpu_id;
        next_we           = 1'b0;
        next_waddr        = '0;
        next_wdata        = '0;
        prev_we           = 1'b0;
        prev_waddr        = '0;
        prev_wdata        = '0;
        meta_we           = 1'b0;
        meta_waddr        = '0;
        meta_wdata        = '0;
        do_unlink         = 1'b0;
        is_head           = 1'b0;
        is_tail           = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_addr_reg;
                if (clr_addr_reg == CPU_W'(NUM_CPUS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + CPU_W'(1);
                end
            end

            S_IDLE:
            begin
                in_stall = out_valid_reg && out_stall;
                if (in_valid && !in_stall)
                begin
                    op_next       = op_t'(operation);
                    slice_next    = slice_in;
                    in_range_next = (int'(cpu_id) < NUM_CPUS);
                    found_next    = any_found;
                    rd_en         = 1'b1;
                    if (op_t'(operation) == OP_DEQUEUE)
                    begin
                        cpu_next  = head_reg[top_level];
                        prio_next = top_level;
                        rd_addr   = head_reg[top_level];
                    end
                    else
                    begin
                        cpu_next  = cpu_id;
                        rd_addr   = cpu_id;
                        if (op_t'(operation) == OP_ENQUEUE
                            && int'(priority_req) > MAX_PRIORITY)
                        begin
                            prio_next = PRIO_W'(MAX_PRIORITY);
                        end
                        else
                        begin
                            prio_next = priority_req;
                        end
                    end
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                out_valid_next    = 1'b1;
                status_next       = STATUS_OK;
                chosen_cpu_next   = '0;
                chosen_slice_next = '0;
                preempt_next      = 1'b0;
                qlen_next         = '0;
                state_next        = S_IDLE;

                case (op_reg)
                    OP_ENQUEUE:
                    begin
                        if (!in_range_reg || rd_queued)
                        begin
                            status_next = STATUS_FAIL;
                        end
                        else
                        begin
                            meta_we    = 1'b1;
                            meta_waddr = cpu_reg;
                            meta_wdata = {1'b1, prio_reg, slice_reg};
                            prev_we    = 1'b1;
                            prev_waddr = cpu_reg;
                            prev_wdata = tail_reg[prio_reg];
                            if (count_reg[prio_reg] != '0)
                            begin
                                next_we    = 1'b1;
                                next_waddr = tail_reg[prio_reg];
                                next_wdata = cpu_reg;
                            end
                            else
                            begin
                                head_next[prio_reg] = cpu_reg;
                            end
                            tail_next[prio_reg]  = cpu_reg;
                            count_next[prio_reg] = count_reg[prio_reg] + CNT_W'(1);
                        end
                    end

                    OP_DEQUEUE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = STATUS_NONE;
                        end
                        else
                        begin
                            do_unlink         = 1'b1;
                            chosen_cpu_next   = cpu_reg;
                            chosen_slice_next = rd_slice;
                        end
                    end

                    OP_DETACH:
                    begin
                        do_unlink = in_range_reg && rd_queued;
                    end

                    OP_PREEMPT:
                    begin
                        preempt_next = pre_any;
                    end

                    OP_LENGTH:
                    begin
                        if (int'(prio_reg) <= MAX_PRIORITY)
                        begin
                            qlen_next = count_reg[prio_reg];
                        end
                    end

                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase

                if (do_unlink)
                begin
                    is_head = (head_reg[rd_prio] == cpu_reg);
                    is_tail = (tail_reg[rd_prio] == cpu_reg);
                    if (is_head)
                    begin
                        head_next[rd_prio] = next_rd;
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd;
                        next_wdata = next_rd;
                    end
                    if (is_tail)
                    begin
                        tail_next[rd_prio] = prev_rd;
                    end
                    else
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rd;
                        prev_wdata = prev_rd;
                    end
                    count_next[rd_prio] = count_reg[rd_prio] - CNT_W'(1);
                    meta_we    = 1'b1;
                    meta_waddr = cpu_reg;
                    meta_wdata = {1'b0, rd_prio, rd_slice};
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                count_reg[lv] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg         <= head_next;
        tail_reg         <= tail_next;
        op_reg           <= op_next;
        cpu_reg          <= cpu_next;
        prio_reg         <= prio_next;
        slice_reg        <= slice_next;
        in_range_reg     <= in_range_next;
        found_reg        <= found_next;
        status_reg       <= status_next;
        chosen_cpu_reg   <= chosen_cpu_next;
        chosen_slice_reg <= chosen_slice_next;
        preempt_reg      <= preempt_next;
        qlen_reg         <= qlen_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign chosen_cpu     = chosen_cpu_reg;
    assign chosen_slice   = chosen_slice_reg;
    assign preempt_needed = preempt_reg;
    assign queue_length   = qlen_reg;

endmodule

// ----- tb/sv/run_queue_checker.sv -----
// ============================================================================
// run_queue_checker
// Watches both channels of the run queue and keeps its own copy of the
// per-level FIFOs. Each accepted transaction is applied to that copy to work
// out its result. Each accepted result is compared field by field with the
// oldest result still due. Mismatches are counted for the testbench top.
// ============================================================================
module run_queue_checker
    import prr_pkg::*;
#(
    parameter int CPU_W  = $clog2(DEFAULT_NUM_CPUS),
    parameter int PRIO_W = $clog2(DEFAULT_MAX_PRIORITY + 1),
    parameter int LEN_W  = $clog2(DEFAULT_NUM_CPUS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [CPU_W-1:0]   cpu_id,
    input  logic [PRIO_W-1:0]  priority_req,
    input  logic [SLICE_W-1:0] slice_in,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic [CPU_W-1:0]   chosen_cpu,
    input  logic [SLICE_W-1:0] chosen_slice,
    input  logic               preempt_needed,
    input  logic [LEN_W-1:0]   queue_length,
    output int                 mismatch_count,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS = DEFAULT_MAX_PRIORITY + 1;

    typedef struct packed {
        status_t            status;
        logic [CPU_W-1:0]   cpu;
        logic [SLICE_W-1:0] slice;
        logic               preempt;
        logic [LEN_W-1:0]   length;
    } run_result_t;

    logic [CPU_W-1:0]   level_fifo [LEVELS][$];
    bit                 cpu_queued [DEFAULT_NUM_CPUS];
    logic [PRIO_W-1:0]  cpu_level  [DEFAULT_NUM_CPUS];
    logic [SLICE_W-1:0] cpu_slice  [DEFAULT_NUM_CPUS];
    run_result_t        due_results [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic run_result_t apply_transaction(
        input logic [2:0]         op,
        input logic [CPU_W-1:0]   cpu,
        input logic [PRIO_W-1:0]  prio,
        input logic [SLICE_W-1:0] slice
    );
        run_result_t res;
        int          lv;
        int          idx;
        res = '0;
        res.status = STATUS_OK;
        case (op_t'(op))
            OP_ENQUEUE:
                if (cpu_queued[cpu]) begin
                    res.status = STATUS_FAIL;
                end else begin
                    level_fifo[prio].push_back(cpu);
                    cpu_queued[cpu] = 1'b1;
                    cpu_level[cpu] = prio;
                    cpu_slice[cpu] = slice;
                end
            OP_DEQUEUE:
            begin
                res.status = STATUS_NONE;
                for (lv = LEVELS - 1; lv >= 0; lv--) begin
                    if (level_fifo[lv].size() != 0) begin
                        res.cpu = level_fifo[lv].pop_front();
                        res.slice = cpu_slice[res.cpu];
                        res.status = STATUS_OK;
                        cpu_queued[res.cpu] = 1'b0;
                        break;
                    end
                end
            end
            OP_DETACH:
                if (cpu_queued[cpu]) begin
                    lv = int'(cpu_level[cpu]);
                    for (idx = 0; idx < level_fifo[lv].size(); idx++) begin
                        if (level_fifo[lv][idx] == cpu) begin
                            level_fifo[lv].delete(idx);
                            break;
                        end
                    end
                    cpu_queued[cpu] = 1'b0;
                end
            OP_PREEMPT:
                for (lv = int'(prio) + 1; lv < LEVELS; lv++) begin
                    if (level_fifo[lv].size() != 0)
                        res.preempt = 1'b1;
                end
            OP_LENGTH:
                res.length = LEN_W'(level_fifo[prio].size());
            default:
                ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        run_result_t want;
        if (!rst_n) begin
            for (int l = 0; l < LEVELS; l++)
                level_fifo[l].delete();
            for (int c = 0; c < DEFAULT_NUM_CPUS; c++)
                cpu_queued[c] = 1'b0;
            due_results.delete();
            mismatch_count = 0;
            outstanding <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with no transaction pending");
                end else begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status: got %0d, expected %0d",
                            status, want.status));
                    if (chosen_cpu !== want.cpu)
                        report_mismatch($sformatf("chosen_cpu: got %0d, expected %0d",
                            chosen_cpu, want.cpu));
                    if (chosen_slice !== want.slice)
                        report_mismatch($sformatf("chosen_slice: got 0x%0h, expected 0x%0h",
                            chosen_slice, want.slice));
                    if (preempt_needed !== want.preempt)
                        report_mismatch($sformatf("preempt_needed: got %0b, expected %0b",
                            preempt_needed, want.preempt));
                    if (queue_length !== want.length)
                        report_mismatch($sformatf("queue_length: got %0d, expected %0d",
                            queue_length, want.length));
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(apply_transaction(operation, cpu_id,
                    priority_req, slice_in));
            outstanding <= due_results.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// ============================================================================
// tb
// Testbench top for the priority run queue. Drives a directed sequence, then
// random phases that fill, churn and drain the per-level FIFOs, with bursty
// input traffic and a changing output stall pattern. The checker instance
// predicts and compares; this module gives the verdict.
// ============================================================================
module tb
    import prr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CPU_W      = $clog2(DEFAULT_NUM_CPUS);
    localparam int PRIO_W     = $clog2(DEFAULT_MAX_PRIORITY + 1);
    localparam int LEN_W      = $clog2(DEFAULT_NUM_CPUS + 1);
    localparam int NUM_ITEMS  = 500;
    localparam int IDLE_LIMIT = 2000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         operation = '0;
    logic [CPU_W-1:0]   cpu_id = '0;
    logic [PRIO_W-1:0]  priority_req = '0;
    logic [SLICE_W-1:0] slice_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [CPU_W-1:0]   chosen_cpu;
    logic [SLICE_W-1:0] chosen_slice;
    logic               preempt_needed;
    logic [LEN_W-1:0]   queue_length;
    int                 mismatch_count;
    int                 outstanding;

    int                 burst_left = 0;
    int                 idle_cycles = 0;
    stall_mode_t        stall_mode = STALL_NONE;
    int                 mode_left = 0;
    int                 run_left = 0;
    logic               run_high = 1'b0;

    always #10 clk = ~clk;

    priority_round_robin_run_queue uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .cpu_id         (cpu_id),
        .priority_req   (priority_req),
        .slice_in       (slice_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .chosen_cpu     (chosen_cpu),
        .chosen_slice   (chosen_slice),
        .preempt_needed (preempt_needed),
        .queue_length   (queue_length)
    );

    run_queue_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .cpu_id         (cpu_id),
        .priority_req   (priority_req),
        .slice_in       (slice_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .chosen_cpu     (chosen_cpu),
        .chosen_slice   (chosen_slice),
        .preempt_needed (preempt_needed),
        .queue_length   (queue_length),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    task automatic send_transaction(
        input logic [2:0]         op,
        input logic [CPU_W-1:0]   cpu,
        input logic [PRIO_W-1:0]  prio,
        input logic [SLICE_W-1:0] slice
    );
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                              : $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        cpu_id <= cpu;
        priority_req <= prio;
        slice_in <= slice;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    function automatic logic [2:0] pick_operation(input int phase);
        int enq_w;
        int deq_w;
        int roll;
        int rest;
        case (phase)
            0:       begin enq_w = 60; deq_w = 10; end
            1:       begin enq_w = 35; deq_w = 30; end
            2:       begin enq_w = 10; deq_w = 60; end
            3:       begin enq_w = 45; deq_w = 25; end
            default: begin enq_w = 25; deq_w = 45; end
        endcase
        roll = $urandom_range(0, 99);
        rest = $urandom_range(0, 9);
        if (roll < enq_w)
            return OP_ENQUEUE;
        if (roll < enq_w + deq_w)
            return OP_DEQUEUE;
        if (rest < 3)
            return OP_DETACH;
        if (rest < 6)
            return OP_PREEMPT;
        if (rest < 9)
            return OP_LENGTH;
        return 3'(OP_LENGTH + $urandom_range(1, 3));
    endfunction

    function automatic logic [SLICE_W-1:0] pick_slice();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return SLICE_W'($urandom);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                default:
                begin
                    if (run_left == 0) begin
                        run_high = !run_high;
                        run_left = $urandom_range(1, 25);
                    end
                    run_left--;
                    out_stall <= run_high;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_transaction(OP_DEQUEUE, 6'd0, 3'd0, '0);
        send_transaction(OP_PREEMPT, 6'd0, 3'd0, '0);
        send_transaction(OP_LENGTH, 6'd0, 3'd0, '0);
        send_transaction(OP_ENQUEUE, 6'd0, 3'd0, '0);
        send_transaction(OP_ENQUEUE, 6'd63, 3'd7, '1);
        send_transaction(OP_ENQUEUE, 6'd63, 3'd3, 32'h5555_5555);
        send_transaction(OP_ENQUEUE, 6'd10, 3'd7, 32'h1234_5678);
        send_transaction(OP_ENQUEUE, 6'd20, 3'd7, 32'hAAAA_AAAA);
        send_transaction(OP_ENQUEUE, 6'd30, 3'd7, 32'h8000_0001);
        send_transaction(OP_LENGTH, 6'd0, 3'd7, '0);
        send_transaction(OP_PREEMPT, 6'd0, 3'd6, '0);
        send_transaction(OP_PREEMPT, 6'd0, 3'd7, '0);
        send_transaction(OP_DETACH, 6'd20, 3'd0, '0);
        send_transaction(OP_DETACH, 6'd63, 3'd0, '0);
        send_transaction(OP_DETACH, 6'd30, 3'd0, '0);
        send_transaction(OP_DETACH, 6'd30, 3'd0, '0);
        for (int u = int'(OP_LENGTH) + 1; u < 8; u++)
            send_transaction(3'(u), 6'd42, 3'd5, SLICE_W'($urandom));
        send_transaction(OP_DEQUEUE, 6'd0, 3'd0, '0);
        send_transaction(OP_DEQUEUE, 6'd0, 3'd0, '0);
        send_transaction(OP_DEQUEUE, 6'd0, 3'd0, '0);
        send_transaction(OP_ENQUEUE, 6'd42, 3'd5, 32'h0F0F_F0F0);
        send_transaction(OP_PREEMPT, 6'd0, 3'd4, '0);
        send_transaction(OP_LENGTH, 6'd0, 3'd5, '0);

        for (int n = 0; n < NUM_ITEMS; n++)
            send_transaction(pick_operation(n / 100), CPU_W'($urandom_range(0, 63)),
                PRIO_W'($urandom_range(0, 7)), pick_slice());
        @(negedge clk);
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
